### rtl/core/rmsd_pkg.sv
// Shared types for the RMS deviation block.
package rmsd_pkg;

  // Status that each serial unit reports back to the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

### rtl/core/rmsd_in_if.sv
// Input channel: one station sample per transaction.
interface rmsd_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] ref_sample;
  logic signed [SAMPLE_BITS-1:0] trace_sample;
  logic                          station_bad;
  logic                          weight_positive;
  logic                          last_station;

  modport source (
    output valid, ref_sample, trace_sample, station_bad, weight_positive, last_station,
    input  ready
  );
  modport sink (
    input  valid, ref_sample, trace_sample, station_bad, weight_positive, last_station,
    output ready
  );
endinterface

### rtl/core/rmsd_out_if.sv
// Output channel: one deviation result per transaction.
interface rmsd_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic        [SAMPLE_BITS-1:0] deviation;
  logic signed [SAMPLE_BITS+1:0] upper_bound;
  logic signed [SAMPLE_BITS+1:0] lower_bound;
  logic                          none_usable;

  modport source (
    output valid, deviation, upper_bound, lower_bound, none_usable,
    input  ready
  );
  modport sink (
    input  valid, deviation, upper_bound, lower_bound, none_usable,
    output ready
  );
endinterface

### rtl/core/rmsd_accum.sv
// Bit-serial square and accumulate of difference magnitudes, with the usable count.
module rmsd_accum #(
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned MAX_STATIONS = 256,
  localparam int unsigned CW  = $clog2(MAX_STATIONS + 1),
  localparam int unsigned PW  = 2 * SAMPLE_BITS,
  localparam int unsigned SW  = PW + CW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      clear_i,
  input  logic [SAMPLE_BITS-1:0]    mag_i,
  output logic [SW-1:0]             sum_o,
  output logic [CW-1:0]             count_o,
  output rmsd_pkg::unit_status_t    status_o
);
  localparam int unsigned BCW = $clog2(SAMPLE_BITS);

  logic [SW-1:0]          sum_q, sum_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [BCW-1:0]         step_q, step_d;
  logic [PW-1:0]          mcand_q, mcand_d;
  logic [SAMPLE_BITS-1:0] mplier_q, mplier_d;

  // One multiplier bit per cycle: the shifted magnitude is added straight into the sum.
  always_comb begin
    sum_d    = sum_q;
    count_d  = count_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    step_d   = step_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (clear_i) begin
      sum_d   = '0;
      count_d = '0;
    end else if (start_i) begin
      mcand_d  = {{SAMPLE_BITS{1'b0}}, mag_i};
      mplier_d = mag_i;
      step_d   = BCW'(SAMPLE_BITS - 1);
      busy_d   = 1'b1;
      count_d  = count_q + CW'(1);
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        sum_d = sum_q + SW'(mcand_q);
      end
      mcand_d  = {mcand_q[PW-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[SAMPLE_BITS-1:1]};
      step_d   = step_q - BCW'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign sum_o           = sum_q;
  assign count_o         = count_q;
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;
endmodule

### rtl/core/rmsd_divider.sv
// Restoring divider, one quotient bit per cycle, for the mean of the squared sum.
module rmsd_divider #(
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned MAX_STATIONS = 256,
  localparam int unsigned CW  = $clog2(MAX_STATIONS + 1),
  localparam int unsigned QW  = 2 * SAMPLE_BITS,
  localparam int unsigned SW  = QW + CW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SW-1:0]          dividend_i,
  input  logic [CW-1:0]          divisor_i,
  output logic [QW-1:0]          quotient_o,
  output rmsd_pkg::unit_status_t status_o
);
  localparam int unsigned SCW = $clog2(QW);

  logic [CW-1:0]  rem_q, rem_d;
  logic [QW-1:0]  quo_q, quo_d;
  logic [CW-1:0]  dvs_q, dvs_d;
  logic [SCW-1:0] step_q, step_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [CW:0]    trial;
  logic           fits;

  // Every square is below 2**QW, so the upper dividend bits are already below the divisor.
  assign trial = {rem_q, quo_q[QW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[SW-1:QW];
      quo_d  = dividend_i[QW-1:0];
      dvs_d  = divisor_i;
      step_d = SCW'(QW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = CW'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[CW-1:0];
      end
      quo_d  = {quo_q[QW-2:0], fits};
      step_d = step_q - SCW'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
endmodule

### rtl/core/rmsd_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module rmsd_sqrt #(
  parameter int unsigned SAMPLE_BITS = 16,
  localparam int unsigned QW = 2 * SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [QW-1:0]          radicand_i,
  output logic [SAMPLE_BITS-1:0] root_o,
  output rmsd_pkg::unit_status_t status_o
);
  localparam int unsigned RW  = SAMPLE_BITS + 2;
  localparam int unsigned SCW = $clog2(SAMPLE_BITS);

  logic [QW-1:0]          rad_q, rad_d;
  logic [RW-1:0]          rem_q, rem_d;
  logic [SAMPLE_BITS-1:0] root_q, root_d;
  logic [SCW-1:0]         step_q, step_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [RW+1:0]          cur;
  logic [RW+1:0]          trial;
  logic                   fits;

  assign cur   = {rem_q, rad_q[QW-1:QW-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign fits  = cur >= trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      step_d = SCW'(SAMPLE_BITS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = RW'(cur - trial);
      end else begin
        rem_d = cur[RW-1:0];
      end
      rad_d  = {rad_q[QW-3:0], 2'b00};
      root_d = {root_q[SAMPLE_BITS-2:0], fits};
      step_d = step_q - SCW'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o        = root_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
endmodule

### rtl/core/rms_deviation_across_traces_unit.sv
// Top level: RMS deviation of station traces around a reference sample.
//
//   Channel  Dir  Carries
//   in_i     in   ref_sample, trace_sample, station_bad, weight_positive, last_station
//   out_o    out  deviation, upper_bound, lower_bound, none_usable
//
// A usable station holds in_i off until the bit-serial square-and-add into the running
// sum is done; a station that is not usable is taken without holding in_i off.
// After the last station ST_DIV runs the divider and ST_ROOT the root, and ST_OUT
// registers the result; with no usable station ST_LAST goes straight to ST_OUT.
// Reset clears the sums, the count and all handshakes; no clearing pass is needed.
// The result register holds a transaction while out_o stalls; accumulation of the
// next point continues, and only its final result waits for the register to free up.
module rms_deviation_across_traces_unit #(
  parameter int unsigned MAX_STATIONS = 256,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rmsd_in_if.sink           in_i,
  rmsd_out_if.source        out_o
);
  localparam int unsigned CW = $clog2(MAX_STATIONS + 1);
  localparam int unsigned QW = 2 * SAMPLE_BITS;
  localparam int unsigned SW = QW + CW;
  localparam int unsigned BW = SAMPLE_BITS + 2;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_STATIONS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_DIV,
    ST_ROOT,
    ST_OUT
  } state_e;

  state_e                        state_q;
  logic signed [SAMPLE_BITS-1:0] ref_q;
  logic                          none_q;
  logic                          none_q_out;
  logic                          out_valid_q;
  logic [SAMPLE_BITS-1:0]        dev_q;
  logic signed [BW-1:0]          upper_q;
  logic signed [BW-1:0]          lower_q;

  logic                          accept;
  logic                          usable;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]          diff_abs;
  logic [SAMPLE_BITS-1:0]        mag;
  logic                          acc_clear;
  logic                          div_start;
  logic                          root_start;
  logic                          slot_free;
  logic [SAMPLE_BITS-1:0]        dev_sel;
  logic signed [BW-1:0]          ref_ext;
  logic signed [BW-1:0]          dev_ext;

  logic [SW-1:0]                 sum;
  logic [CW-1:0]                 count;
  logic [QW-1:0]                 quotient;
  logic [SAMPLE_BITS-1:0]        root;
  rmsd_pkg::unit_status_t        acc_st;
  rmsd_pkg::unit_status_t        div_st;
  rmsd_pkg::unit_status_t        root_st;

  assign in_i.ready = (state_q == ST_IDLE) && !acc_st.busy;
  assign accept     = in_i.valid && in_i.ready;
  assign usable     = !in_i.station_bad && in_i.weight_positive && (count < MaxCount);

  // The difference of two samples never reaches 2**SAMPLE_BITS in magnitude.
  assign diff     = (SAMPLE_BITS + 1)'(in_i.ref_sample) - (SAMPLE_BITS + 1)'(in_i.trace_sample);
  assign diff_abs = diff[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-diff) : diff;
  assign mag      = diff_abs[SAMPLE_BITS-1:0];

  assign acc_clear  = (state_q == ST_LAST) && !acc_st.busy;
  assign div_start  = acc_clear && (count != '0);
  assign root_start = (state_q == ST_DIV) && div_st.done;
  assign slot_free  = !out_valid_q || out_o.ready;

  assign dev_sel = none_q ? '0 : root;
  assign ref_ext = BW'(ref_q);
  assign dev_ext = BW'({2'b00, dev_sel});

  rmsd_accum #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_STATIONS (MAX_STATIONS)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && usable),
    .clear_i  (acc_clear),
    .mag_i    (mag),
    .sum_o    (sum),
    .count_o  (count),
    .status_o (acc_st)
  );

  rmsd_divider #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_STATIONS (MAX_STATIONS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum),
    .divisor_i  (count),
    .quotient_o (quotient),
    .status_o   (div_st)
  );

  rmsd_sqrt #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (quotient),
    .root_o     (root),
    .status_o   (root_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ref_q       <= '0;
      none_q      <= 1'b0;
      out_valid_q <= 1'b0;
      dev_q       <= '0;
      upper_q     <= '0;
      lower_q     <= '0;
    end else begin
      // In ST_OUT the slot is free whenever the held transaction leaves, so it reloads.
      if (out_valid_q && out_o.ready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && in_i.last_station) begin
            ref_q   <= in_i.ref_sample;
            state_q <= ST_LAST;
          end
        end
        ST_LAST: begin
          // Wait for the last station's square to land in the sum.
          if (!acc_st.busy) begin
            none_q  <= (count == '0);
            state_q <= (count == '0) ? ST_OUT : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_st.done) begin
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_st.done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            dev_q       <= dev_sel;
            upper_q     <= ref_ext + dev_ext;
            lower_q     <= ref_ext - dev_ext;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.deviation   = dev_q;
  assign out_o.upper_bound = upper_q;
  assign out_o.lower_bound = lower_q;
  assign out_o.none_usable = none_q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      none_q_out <= 1'b0;
    end else if (state_q == ST_OUT && slot_free) begin
      none_q_out <= none_q;
    end
  end
endmodule

### tb/rms_deviation_across_traces_unit_tb.sv
// Testbench for the RMS deviation block: directed and random station streams.
`timescale 1ns / 1ps

module rms_deviation_across_traces_unit_tb;

  localparam int unsigned MAX_STATIONS = 256;
  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // A usable station is squared and added first, then divide, root and control follow.
  localparam int unsigned SETTLE_CYCLES = 200;

  typedef struct {
    logic        [15:0] deviation;
    logic signed [17:0] upper_bound;
    logic signed [17:0] lower_bound;
    logic               none_usable;
  } deviation_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  rmsd_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  rmsd_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_if ();

  rms_deviation_across_traces_unit #(
    .MAX_STATIONS(MAX_STATIONS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Running state of the point being accumulated.
  logic [40:0] acc_sq_sum = '0;
  int unsigned acc_count  = 0;
  deviation_t  pending_deviations[$];

  int unsigned mismatches      = 0;
  int unsigned stations_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned empty_points    = 0;
  int unsigned saturated_points = 0;
  int unsigned cycle_count     = 0;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;

  function automatic logic [31:0] floor_root(input logic [63:0] x);
    logic [31:0] res;
    logic [31:0] trial;
    logic [63:0] wide;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (32'd1 << b);
      wide = 64'(trial);
      if (wide * wide <= x) begin
        res = trial;
      end
    end
    return res;
  endfunction

  task automatic accumulate_station(input logic signed [15:0] ref_s,
                                    input logic signed [15:0] trc_s,
                                    input logic bad, input logic wpos, input logic last);
    int         diff;
    deviation_t r;
    if (!bad && wpos && acc_count < MAX_STATIONS) begin
      diff = int'(ref_s) - int'(trc_s);
      acc_sq_sum += 41'(longint'(diff) * longint'(diff));
      acc_count++;
    end else if (!bad && wpos) begin
      saturated_points += (acc_count == MAX_STATIONS) ? 1 : 0;
    end
    if (last) begin
      r.none_usable = (acc_count == 0);
      r.deviation   = '0;
      if (acc_count != 0) begin
        r.deviation = 16'(floor_root(64'(acc_sq_sum) / acc_count));
      end
      r.upper_bound = 18'(int'(ref_s) + int'(r.deviation));
      r.lower_bound = 18'(int'(ref_s) - int'(r.deviation));
      empty_points += r.none_usable ? 1 : 0;
      pending_deviations.push_back(r);
      acc_sq_sum = '0;
      acc_count  = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  // Offers one station and waits for its transaction; the prediction follows acceptance.
  task automatic offer_station(input logic signed [15:0] ref_s, input logic signed [15:0] trc_s,
                               input logic bad, input logic wpos, input logic last);
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_if.valid           <= 1'b1;
    in_if.ref_sample      <= ref_s;
    in_if.trace_sample    <= trc_s;
    in_if.station_bad     <= bad;
    in_if.weight_positive <= wpos;
    in_if.last_station    <= last;
    do @(posedge clk_i); while (!in_if.ready);
    stations_sent++;
    accumulate_station(ref_s, trc_s, bad, wpos, last);
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (pending_deviations.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Result checker: every result transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    deviation_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_deviations.size() == 0) begin
        report_mismatch("result with nothing pending, deviation", out_if.deviation, 0);
      end else begin
        want = pending_deviations.pop_front();
        results_checked++;
        if (out_if.deviation !== want.deviation)
          report_mismatch("deviation", out_if.deviation, want.deviation);
        if (out_if.upper_bound !== want.upper_bound)
          report_mismatch("upper_bound", out_if.upper_bound, want.upper_bound);
        if (out_if.lower_bound !== want.lower_bound)
          report_mismatch("lower_bound", out_if.lower_bound, want.lower_bound);
        if (out_if.none_usable !== want.none_usable)
          report_mismatch("none_usable", out_if.none_usable, want.none_usable);
      end
    end
  end

  // Result-side ready, with an optional long hold-off counted here.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_request != 0) begin
      hold_left = hold_request - 1;
      hold_request = 0;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_deviations.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed_extremes();
    // Largest possible difference in both directions, with one station each.
    offer_station(16'sh7FFF, 16'sh8000, 1'b0, 1'b1, 1'b1);
    offer_station(16'sh8000, 16'sh7FFF, 1'b0, 1'b1, 1'b1);
    offer_station(16'sh0000, 16'sh0000, 1'b0, 1'b1, 1'b1);
    // Points where no station counts: bad, zero weight, and both.
    offer_station(16'sh1234, 16'sh0000, 1'b1, 1'b1, 1'b1);
    offer_station(16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 1'b1);
    offer_station(16'sh7FFF, 16'sh8000, 1'b1, 1'b0, 1'b1);
    // Each station uses its own reference; the bounds use the last one.
    offer_station(16'sd100, 16'sd0, 1'b0, 1'b1, 1'b0);
    offer_station(-16'sd5, 16'sd40, 1'b0, 1'b1, 1'b0);
    offer_station(16'sd2000, 16'sd1990, 1'b0, 1'b1, 1'b1);
    // An unusable last station still closes the point.
    offer_station(16'sd7, 16'sd3, 1'b1, 1'b1, 1'b0);
    offer_station(16'sd7, -16'sd9, 1'b0, 1'b1, 1'b0);
    offer_station(-16'sd7, 16'sd7, 1'b0, 1'b0, 1'b1);
    // The mean is truncated before the root: (9 + 16) / 2 = 12, root 3.
    offer_station(16'sd10, 16'sd7, 1'b0, 1'b1, 1'b0);
    offer_station(16'sd10, 16'sd6, 1'b0, 1'b1, 1'b1);
    wait_for_results();
  endtask

  task automatic test_count_saturation();
    // 256 small differences fill the count; the large ones after it must be dropped.
    for (int i = 0; i < MAX_STATIONS; i++) begin
      offer_station(16'sd300, 16'(300 - int'($urandom_range(60))), 1'b0, 1'b1, 1'b0);
    end
    offer_station(16'sh7FFF, 16'sh8000, 1'b0, 1'b1, 1'b0);
    offer_station(16'sh0000, 16'sh0000, 1'b1, 1'b1, 1'b0);
    offer_station(16'sh8000, 16'sh7FFF, 1'b0, 1'b1, 1'b0);
    offer_station(16'sh7FFF, 16'sh8000, 1'b0, 1'b1, 1'b1);
    wait_for_results();
  endtask

  task automatic send_random_point();
    int               n;
    bit               all_unusable;
    bit               same_ref;
    logic signed [15:0] point_ref;
    logic signed [15:0] r;
    logic signed [15:0] t;
    logic             bad;
    logic             wpos;
    n = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
    all_unusable = ($urandom_range(99) < 8);
    same_ref = ($urandom_range(99) < 80);
    point_ref = pick_sample();
    for (int i = 0; i < n; i++) begin
      r = same_ref ? point_ref : pick_sample();
      if ($urandom_range(3) == 0) t = pick_sample();
      else t = 16'(int'(r) + int'($urandom_range(400)) - 200);
      if (all_unusable) begin
        bad  = 1'($urandom_range(1));
        wpos = bad ? 1'($urandom_range(1)) : 1'b0;
      end else if ($urandom_range(99) < 75) begin
        bad  = 1'b0;
        wpos = 1'b1;
      end else begin
        bad  = 1'($urandom_range(1));
        wpos = 1'($urandom_range(1));
      end
      offer_station(r, t, bad, wpos, i == n - 1);
    end
  endtask

  task automatic test_random_points(input int unsigned src_pct, input int unsigned sink_pct,
                                    input int unsigned n_stations);
    int unsigned start;
    start = stations_sent;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    while (stations_sent - start < n_stations) send_random_point();
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    // The result side holds off while points keep coming, so the input must stall.
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_request   = 400;
    for (int i = 0; i < 14; i++) begin
      offer_station(pick_sample(), pick_sample(), 1'b0, 1'b1, 1'b0);
      offer_station(pick_sample(), pick_sample(), 1'b0, 1'b1, 1'b0);
      offer_station(pick_sample(), pick_sample(), 1'b0, 1'b1, 1'b1);
    end
    wait_for_results();
  endtask

  task automatic test_pause_until_drained();
    src_idle_pct   = 31;
    sink_stall_pct = 31;
    for (int k = 0; k < 4; k++) begin
      send_random_point();
      wait_for_results();
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  initial begin
    in_if.valid           <= 1'b0;
    in_if.ref_sample      <= '0;
    in_if.trace_sample    <= '0;
    in_if.station_bad     <= 1'b0;
    in_if.weight_positive <= 1'b0;
    in_if.last_station    <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_count_saturation();
    test_random_points(0, 0, 300);
    test_random_points(87, 0, 300);
    test_random_points(0, 87, 300);
    test_random_points(31, 31, 300);
    test_output_backpressure();
    test_pause_until_drained();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d stations, checked %0d deviation results (%0d with no usable station).",
             stations_sent, results_checked, empty_points);
    $display("Covered count saturation (%0d stations dropped), long result hold-off and idle mixes.",
             saturated_points);
    if (mismatches == 0 && pending_deviations.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/rmsd_pkg.sv
rtl/core/rmsd_in_if.sv
rtl/core/rmsd_out_if.sv
rtl/core/rmsd_accum.sv
rtl/core/rmsd_divider.sv
rtl/core/rmsd_sqrt.sv
rtl/core/rms_deviation_across_traces_unit.sv
tb/rms_deviation_across_traces_unit_tb.sv
